// File: src/ekpe_pkg.sv
// Shared types and constants for the encoder knob parameter editor.
// No dependencies.
package ekpe_pkg;

	localparam int VALUE_W    = 20;
	localparam int STEP_W     = 10;
	localparam int IDX_W      = 2;
	localparam int OUT_VALUES = 4;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam logic [IDX_W-1:0] STEP_HUNDREDTH = 2'd0;
	localparam logic [IDX_W-1:0] STEP_TENTH     = 2'd1;
	localparam logic [IDX_W-1:0] STEP_UNIT      = 2'd2;
	localparam logic [IDX_W-1:0] STEP_TEN       = 2'd3;

	typedef struct packed {
		logic               mode;
		logic               enc_a;
		logic               enc_b;
		logic               enc_switch;
		logic               menu_button;
		logic [IDX_W-1:0]   load_index;
		logic [VALUE_W-1:0] load_value;
	} ekpe_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]                      selected_index;
		logic [IDX_W-1:0]                      step_index;
		logic [VALUE_W-1:0]                    selected_value;
		logic [OUT_VALUES-1:0][VALUE_W-1:0]    values;
		logic                                  adjusted;
	} ekpe_result_t;

	// step size in hundredths
	function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] sel);
		logic [STEP_W-1:0] s;
		unique case (sel)
			STEP_HUNDREDTH: s = 10'd1;
			STEP_TENTH:     s = 10'd10;
			STEP_UNIT:      s = 10'd100;
			STEP_TEN:       s = 10'd1000;
			default:        s = 10'd1;
		endcase
		return s;
	endfunction

endpackage

// File: src/ekpe_in_reg.sv
// Input register: holds one accepted transaction until the update stage takes it.
// Depends on ekpe_pkg.
module ekpe_in_reg
	import ekpe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       advance,
	input  ekpe_item_t item_in,
	output logic       valid_s1,
	output ekpe_item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: src/ekpe_update.sv
// Edge detection, menu/step state and the stored value file with clamped adjust and direct loads.
// Depends on ekpe_pkg.
module ekpe_update
	import ekpe_pkg::*;
#(
	parameter int NUM_VALUES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  ekpe_item_t   item,
	output ekpe_result_t result
);

	localparam int MIDX_W = $clog2(NUM_VALUES);

	logic [VALUE_W-1:0] vals_q [NUM_VALUES];
	logic [VALUE_W-1:0] vals_d [NUM_VALUES];
	logic [MIDX_W-1:0]  menu_q, menu_d;
	logic [IDX_W-1:0]   step_q, step_d;
	logic               sw_prev_q, sw_prev_d;
	logic               btn_prev_q, btn_prev_d;
	logic               a_prev_q, a_prev_d;
	logic               load_ok;
	logic [VALUE_W-1:0] old_val, new_val;
	logic [VALUE_W:0]   sum;
	logic [STEP_W-1:0]  step_amt;
	logic               adjusted;

	assign load_ok = 32'(item.load_index) < 32'(NUM_VALUES);

	always_comb begin
		vals_d     = vals_q;
		menu_d     = menu_q;
		step_d     = step_q;
		sw_prev_d  = sw_prev_q;
		btn_prev_d = btn_prev_q;
		a_prev_d   = a_prev_q;
		old_val    = '0;
		new_val    = '0;
		sum        = '0;
		step_amt   = '0;
		adjusted   = 1'b0;
		if (item.mode == MODE_LOAD) begin
			if (load_ok) begin
				vals_d[MIDX_W'(item.load_index)] = item.load_value;
			end
		end else begin
			if (!item.enc_switch && sw_prev_q) begin
				step_d = step_d + 1'b1;
			end
			sw_prev_d = item.enc_switch;
			if (!item.menu_button && btn_prev_q) begin
				step_d = STEP_HUNDREDTH;
				menu_d = (menu_q == MIDX_W'(NUM_VALUES - 1)) ? '0 : menu_q + 1'b1;
			end
			btn_prev_d = item.menu_button;
			if (item.enc_a && !a_prev_q) begin
				old_val  = vals_q[menu_d];
				step_amt = step_size(step_d);
				if (item.enc_b != item.enc_a) begin
					new_val = (old_val > VALUE_W'(step_amt)) ?
						old_val - VALUE_W'(step_amt) : '0;
				end else begin
					sum     = {1'b0, old_val} + (VALUE_W+1)'(step_amt);
					new_val = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
				end
				adjusted       = new_val != old_val;
				vals_d[menu_d] = new_val;
			end
			a_prev_d = item.enc_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VALUES; i++) begin
				vals_q[i] <= '0;
			end
			menu_q     <= '0;
			step_q     <= STEP_HUNDREDTH;
			sw_prev_q  <= 1'b1;
			btn_prev_q <= 1'b1;
			a_prev_q   <= 1'b0;
		end else if (fire) begin
			vals_q     <= vals_d;
			menu_q     <= menu_d;
			step_q     <= step_d;
			sw_prev_q  <= sw_prev_d;
			btn_prev_q <= btn_prev_d;
			a_prev_q   <= a_prev_d;
		end
	end

	assign result.selected_index = IDX_W'(menu_d);
	assign result.step_index     = step_d;
	assign result.selected_value = vals_d[menu_d];
	assign result.adjusted       = (item.mode == MODE_TICK) && adjusted;

	for (genvar g = 0; g < OUT_VALUES; g++) begin : g_tap
		if (g < NUM_VALUES) begin : g_real
			assign result.values[g] = vals_d[g];
		end else begin : g_none
			assign result.values[g] = '0;
		end
	end

endmodule

// File: src/ekpe_out_reg.sv
// Result register: holds one result until the receiver takes it.
// Depends on ekpe_pkg.
module ekpe_out_reg
	import ekpe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic         taken,
	input  ekpe_result_t result,
	output logic         valid_q,
	output ekpe_result_t result_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

// File: src/encoder_knob_parameter_editor.sv
// Encoder knob parameter editor: top level.
// An accepted transaction waits in the input register until fire registers its result.
// Throughput: one transaction per cycle unless the output stalls, set by the single update stage and its state.
// Reset (arst_n low, asynchronous): values, menu and step cleared, button history high.
// Depends on ekpe_pkg, ekpe_in_reg, ekpe_update, ekpe_out_reg.
module encoder_knob_parameter_editor
	import ekpe_pkg::*;
#(
	parameter int NUM_VALUES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic               enc_a,
	input  logic               enc_b,
	input  logic               enc_switch,
	input  logic               menu_button,
	input  logic [IDX_W-1:0]   load_index,
	input  logic [VALUE_W-1:0] load_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   selected_index,
	output logic [IDX_W-1:0]   step_index,
	output logic [VALUE_W-1:0] selected_value,
	output logic [VALUE_W-1:0] value_zero,
	output logic [VALUE_W-1:0] value_one,
	output logic [VALUE_W-1:0] value_two,
	output logic [VALUE_W-1:0] value_three,
	output logic               adjusted
);

	ekpe_item_t   item_in, item_s1;
	ekpe_result_t result, result_q;
	logic         valid_s1, advance, take, fire, taken;

	assign item_in = '{mode: mode, enc_a: enc_a, enc_b: enc_b, enc_switch: enc_switch,
		menu_button: menu_button, load_index: load_index, load_value: load_value};

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;
	assign taken    = out_valid && !out_stall;

	ekpe_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.advance  (advance),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ekpe_update #(
		.NUM_VALUES (NUM_VALUES)
	) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	ekpe_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.taken    (taken),
		.result   (result),
		.valid_q  (out_valid),
		.result_q (result_q)
	);

	assign selected_index = result_q.selected_index;
	assign step_index     = result_q.step_index;
	assign selected_value = result_q.selected_value;
	assign value_zero     = result_q.values[0];
	assign value_one      = result_q.values[1];
	assign value_two      = result_q.values[2];
	assign value_three    = result_q.values[3];
	assign adjusted       = result_q.adjusted;

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("result register empty after a transaction left stage one");

	a_stall_needs_full_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked pipeline");

	a_drain_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		taken && !fire |=> !out_valid)
		else $error("result register still valid after drain");

	a_adjust_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.mode == MODE_LOAD |-> !result.adjusted)
		else $error("load transaction flagged as adjusted");

endmodule
